// ----- hdl/checked_message_fifo_defines.svh -----
// ---------------------------------------------------------------------------
// checked message fifo assertion macros
// shared assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef CHECKED_MESSAGE_FIFO_DEFINES_SVH
`define CHECKED_MESSAGE_FIFO_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checked_message_fifo assertion failed");

// next-cycle implication, disabled in reset
`define CMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checked_message_fifo assertion failed");

`endif

// ----- hdl/cmf_pkg.sv -----
// ---------------------------------------------------------------------------
// cmf_pkg
// types, constants and helpers of the checked message fifo
// ---------------------------------------------------------------------------
package cmf_pkg;

  localparam int DEPTH_DEF             = 16;
  localparam int MAX_PAYLOAD_BYTES_DEF = 128;

  localparam int HOST_W     = 8;
  localparam int LEN_W      = 8;
  localparam int WORD_W     = 64;
  localparam int CAP_W      = 5;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int WC_W       = 6;
  localparam int CMP_W      = 16;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_REQ  = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRODUCER = 2'd0,
    CFG_CONSUMER = 2'd1,
    CFG_CAPACITY = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_RESP,
    S_POP_HDR,
    S_POP_WR
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HOST_W-1:0] dst;
    logic [HOST_W-1:0] src;
    logic [7:0]        mk;
  } hdr_t;

  // words a message of len bytes occupies, at least one
  function automatic logic [WC_W-1:0] word_count(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] sum;
    sum = {1'b0, len} + (LEN_W + 1)'(7);
    if (len == '0) begin
      return WC_W'(1);
    end
    return WC_W'(sum >> 3);
  endfunction

  // zero the bytes at or beyond len
  function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] word,
                                                   input logic [CMP_W-1:0]  byte_base,
                                                   input logic [LEN_W-1:0]  len);
    logic [WORD_W-1:0] m;
    m = word;
    for (int b = 0; b < 8; b++) begin
      if (byte_base + CMP_W'(b) >= CMP_W'(len)) begin
        m[8*b +: 8] = 8'h00;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/cmf_if.sv -----
// ---------------------------------------------------------------------------
// cmf_if
// valid/ready channels of the checked message fifo
// ---------------------------------------------------------------------------
interface cmf_in_if import cmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [HOST_W-1:0] requester_host;
  logic [7:0]        msg_kind;
  logic [HOST_W-1:0] msg_src;
  logic [HOST_W-1:0] msg_dst;
  logic [LEN_W-1:0]  payload_len;
  logic [WORD_W-1:0] payload_word;
  logic              beat_last;

  modport source (
    output valid, kind, requester_host, msg_kind, msg_src, msg_dst,
           payload_len, payload_word, beat_last,
    input  ready
  );
  modport sink (
    input  valid, kind, requester_host, msg_kind, msg_src, msg_dst,
           payload_len, payload_word, beat_last,
    output ready
  );
endinterface

interface cmf_out_if import cmf_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [7:0]        out_kind;
  logic [HOST_W-1:0] out_src;
  logic [HOST_W-1:0] out_dst;
  logic [LEN_W-1:0]  out_len;
  logic [WORD_W-1:0] out_word;
  logic              out_last;
  logic [OCC_W-1:0]  occupancy;

  modport source (
    output valid, status, out_kind, out_src, out_dst, out_len, out_word,
           out_last, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_kind, out_src, out_dst, out_len, out_word,
           out_last, occupancy,
    output ready
  );
endinterface

// ----- hdl/cmf_check.sv -----
// ---------------------------------------------------------------------------
// cmf_check
// ordered admission checks on the final beat of a push
// ---------------------------------------------------------------------------
module cmf_check import cmf_pkg::*; #(
  parameter  int MAX_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int MAX_WORDS = (MAX_BYTES + 7) / 8,
  localparam int SC_W      = $clog2(MAX_WORDS + 1)
) (
  input  hdr_t              hdr,
  input  logic [HOST_W-1:0] requester,
  input  logic [HOST_W-1:0] producer,
  input  logic [HOST_W-1:0] consumer,
  input  logic [SC_W-1:0]   beats,
  input  logic              overflow,
  input  logic              full,
  output status_t           status
);

  logic [WC_W-1:0] need;
  logic            count_bad;
  logic            hdr_bad;
  logic            too_long;

  always_comb begin
    need = word_count(hdr.len);
    // with dropped beats the count only matches a claim that also overflows
    if (overflow) begin
      count_bad = CMP_W'(need) <= CMP_W'(MAX_WORDS);
    end else begin
      count_bad = CMP_W'(beats) != CMP_W'(need);
    end
    hdr_bad  = (hdr.mk == '0) || (hdr.src != producer) || (hdr.dst != consumer) || count_bad;
    too_long = (CMP_W'(hdr.len) > CMP_W'(MAX_BYTES)) || overflow;

    if (requester != producer) begin
      status = ST_BAD_REQ;
    end else if (hdr_bad) begin
      status = ST_BAD_HDR;
    end else if (too_long) begin
      status = ST_TOO_LONG;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// ----- hdl/checked_message_fifo.sv -----
// Push beats: one per cycle while idle. A failing final beat's status is registered, then
// enters the result register once free; a committed push copies its staged words at one per
// cycle. Pop: header read, payload read, then one word per cycle from payload memory while
// output is free. One access at a time; the next is taken once its last result is registered.
// Reset is synchronous and clears the indices, counts and state; the memories are not cleared.
// ---------------------------------------------------------------------------
// checked_message_fifo
// single-producer single-consumer message ring with checked pushes
// ---------------------------------------------------------------------------
module checked_message_fifo import cmf_pkg::*; #(
  parameter int DEPTH             = DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cmf_in_if.sink                in_ch,
  cmf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAX_WORDS = (MAX_PAYLOAD_BYTES + 7) / 8;
  localparam int SC_W      = $clog2(MAX_WORDS + 1);
  localparam int SI_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HC_W      = $clog2(DEPTH + 1);
  localparam int PA_DEPTH  = DEPTH * MAX_WORDS;
  localparam int PA_W      = (PA_DEPTH > 1) ? $clog2(PA_DEPTH) : 1;

  // configuration
  logic [HOST_W-1:0] producer_r;
  logic [HOST_W-1:0] consumer_r;
  logic [CAP_W-1:0]  cap_r;

  // control state
  state_t            state_r, state_nxt;
  logic [SC_W-1:0]   stg_cnt_r, stg_cnt_nxt;
  logic              stg_ovf_r, stg_ovf_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [HC_W-1:0]   held_r, held_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              out_valid_r;

  // working registers
  logic [SC_W-1:0]   cnt_r, cnt_nxt;
  logic [SC_W-1:0]   n_r, n_nxt;
  logic [PA_W-1:0]   base_r, base_nxt;
  logic [PA_W-1:0]   pwaddr_r, pwaddr_nxt;
  hdr_t              hdr_r, hdr_nxt;
  status_t           res_status_r, res_status_nxt;

  // result register
  status_t           out_status_r, out_status_nxt;
  hdr_t              out_hdr_r, out_hdr_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic [OCC_W-1:0]  out_occ_r;
  logic              out_load;
  logic              out_free;

  // memories
  logic [WORD_W-1:0] stg_mem [MAX_WORDS];
  hdr_t              hdr_mem [DEPTH];
  logic [WORD_W-1:0] pay_mem [PA_DEPTH];
  logic [WORD_W-1:0] stg_rdata_r;
  hdr_t              hdr_rdata_r;
  logic [WORD_W-1:0] pay_rdata_r;
  logic              stg_we, stg_ren, hdr_we, hdr_ren, pay_ren;
  logic [SI_W-1:0]   stg_raddr;
  logic [PA_W-1:0]   pay_raddr;

  // derived
  logic [CMP_W-1:0]  cap_eff;
  logic              full;
  logic              stg_room;
  logic [SC_W-1:0]   beats;
  logic              ovf_now;
  logic [IDX_W-1:0]  rd_adv, wr_adv;
  hdr_t              hdr_in;
  status_t           chk_status;
  logic [SC_W-1:0]   cnt_inc;
  logic [WC_W-1:0]   pop_wc;
  logic [CMP_W-1:0]  byte_base;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
    full     = CMP_W'(held_r) >= cap_eff;
    stg_room = CMP_W'(stg_cnt_r) < CMP_W'(MAX_WORDS);
    beats    = stg_room ? stg_cnt_r + 1'b1 : stg_cnt_r;
    ovf_now  = stg_ovf_r | ~stg_room;
    rd_adv   = (CMP_W'(rd_idx_r) + CMP_W'(1) >= cap_eff) ? '0 : rd_idx_r + 1'b1;
    wr_adv   = (CMP_W'(wr_idx_r) + CMP_W'(1) >= cap_eff) ? '0 : wr_idx_r + 1'b1;
    hdr_in.len = in_ch.payload_len;
    hdr_in.dst = in_ch.msg_dst;
    hdr_in.src = in_ch.msg_src;
    hdr_in.mk  = in_ch.msg_kind;
    cnt_inc    = cnt_r + 1'b1;
    pop_wc     = word_count(hdr_rdata_r.len);
    byte_base  = CMP_W'(cnt_r) << 3;
  end

  cmf_check #(
    .MAX_BYTES (MAX_PAYLOAD_BYTES)
  ) u_cmf_check (
    .hdr       (hdr_in),
    .requester (in_ch.requester_host),
    .producer  (producer_r),
    .consumer  (consumer_r),
    .beats     (beats),
    .overflow  (ovf_now),
    .full      (full),
    .status    (chk_status)
  );

  assign out_free = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    stg_cnt_nxt    = stg_cnt_r;
    stg_ovf_nxt    = stg_ovf_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    held_nxt       = held_r;
    wr_pend_nxt    = 1'b0;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    base_nxt       = base_r;
    pwaddr_nxt     = pwaddr_r;
    hdr_nxt        = hdr_r;
    res_status_nxt = res_status_r;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_hdr_nxt    = '0;
    out_word_nxt   = '0;
    out_last_nxt   = 1'b1;
    stg_we         = 1'b0;
    stg_ren        = 1'b0;
    stg_raddr      = cnt_r[SI_W-1:0];
    hdr_we         = 1'b0;
    hdr_ren        = 1'b0;
    pay_ren        = 1'b0;
    pay_raddr      = base_r;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == KIND_POP) begin
            if (in_ch.requester_host != consumer_r) begin
              res_status_nxt = ST_BAD_REQ;
              state_nxt      = S_RESP;
            end else if (held_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              hdr_ren    = 1'b1;
              base_nxt   = PA_W'(rd_idx_r) * PA_W'(MAX_WORDS);
              rd_idx_nxt = rd_adv;
              held_nxt   = held_r - 1'b1;
              state_nxt  = S_POP_HDR;
            end
          end else begin
            if (stg_room) begin
              stg_we      = 1'b1;
              stg_cnt_nxt = stg_cnt_r + 1'b1;
            end else begin
              stg_ovf_nxt = 1'b1;
            end
            if (in_ch.beat_last) begin
              stg_cnt_nxt    = '0;
              stg_ovf_nxt    = 1'b0;
              res_status_nxt = chk_status;
              if (chk_status == ST_OK) begin
                hdr_we     = 1'b1;
                base_nxt   = PA_W'(wr_idx_r) * PA_W'(MAX_WORDS);
                n_nxt      = beats;
                cnt_nxt    = '0;
                wr_idx_nxt = wr_adv;
                held_nxt   = held_r + 1'b1;
                state_nxt  = S_COPY;
              end else begin
                state_nxt = S_RESP;
              end
            end
          end
        end
      end
      S_COPY: begin
        // payload write in the cycle after each staging read
        if (cnt_r != n_r) begin
          stg_ren     = 1'b1;
          cnt_nxt     = cnt_inc;
          wr_pend_nxt = 1'b1;
          pwaddr_nxt  = base_r + PA_W'(cnt_r);
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      S_POP_HDR: begin
        hdr_nxt = hdr_rdata_r;
        if (CMP_W'(pop_wc) > CMP_W'(MAX_WORDS)) begin
          n_nxt = SC_W'(MAX_WORDS);
        end else begin
          n_nxt = SC_W'(pop_wc);
        end
        cnt_nxt   = '0;
        pay_ren   = 1'b1;
        pay_raddr = base_r;
        state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        // read data holds until the result register takes it
        if (out_free) begin
          out_load     = 1'b1;
          out_hdr_nxt  = hdr_r;
          out_word_nxt = mask_word(pay_rdata_r, byte_base, hdr_r.len);
          out_last_nxt = (cnt_inc == n_r);
          if (cnt_inc == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_inc;
            pay_ren   = 1'b1;
            pay_raddr = base_r + PA_W'(cnt_inc);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      stg_cnt_r <= '0;
      stg_ovf_r <= 1'b0;
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      held_r    <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      stg_ovf_r <= stg_ovf_nxt;
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      held_r    <= held_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    n_r          <= n_nxt;
    base_r       <= base_nxt;
    pwaddr_r     <= pwaddr_nxt;
    hdr_r        <= hdr_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      producer_r <= '0;
      consumer_r <= HOST_W'(1);
      cap_r      <= CAP_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PRODUCER: producer_r <= cfg_wdata[HOST_W-1:0];
        CFG_CONSUMER: consumer_r <= cfg_wdata[HOST_W-1:0];
        CFG_CAPACITY: cap_r      <= cfg_wdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_cnt_r[SI_W-1:0]] <= in_ch.payload_word;
    end
    if (stg_ren) begin
      stg_rdata_r <= stg_mem[stg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[wr_idx_r] <= hdr_in;
    end
    if (hdr_ren) begin
      hdr_rdata_r <= hdr_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      pay_mem[pwaddr_r] <= stg_rdata_r;
    end
    if (pay_ren) begin
      pay_rdata_r <= pay_mem[pay_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_hdr_r    <= out_hdr_nxt;
      out_word_r   <= out_word_nxt;
      out_last_r   <= out_last_nxt;
      out_occ_r    <= OCC_W'(held_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_kind  = out_hdr_r.mk;
  assign out_ch.out_src   = out_hdr_r.src;
  assign out_ch.out_dst   = out_hdr_r.dst;
  assign out_ch.out_len   = out_hdr_r.len;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

// ----- hdl/cmf_checker.sv -----
// ---------------------------------------------------------------------------
// cmf_checker
// port-level checks of the checked message fifo, bound to the top level
// ---------------------------------------------------------------------------
`include "checked_message_fifo_defines.svh"

module cmf_checker import cmf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input status_t           out_status,
  input logic [7:0]        out_kind,
  input logic [WORD_W-1:0] out_word,
  input logic              out_last,
  input logic [OCC_W-1:0]  out_occ
);

  `CMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CMF_ASSERT_IMPL(a_mid_beat_ok, out_valid && !out_last, out_status == ST_OK)
  `CMF_ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_OK, out_kind == '0 && out_word == '0)
  `CMF_ASSERT_IMPL(a_empty_occ, out_valid && out_status == ST_EMPTY, out_occ == '0)
  `CMF_ASSERT_IMPL(a_stream_stall, out_valid && !out_last, !in_ready)

endmodule

bind checked_message_fifo cmf_checker u_cmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_kind   (out_ch.out_kind),
  .out_word   (out_ch.out_word),
  .out_last   (out_ch.out_last),
  .out_occ    (out_ch.occupancy)
);

// ----- bench/tb_checked_message_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_checked_message_fifo
// Self-checking bench for the checked message ring. A shadow copy of the
// ring predicts every reply from the input beats it sees accepted. A monitor
// compares each reply beat against the oldest prediction. Directed tests hit
// the header checks, full, empty, capacity clamping and index wrap. Random
// phases then mix traffic under bursty input and a stalling receiver.
// ---------------------------------------------------------------------------
module tb_checked_message_fifo;
  import cmf_pkg::*;

  localparam int RING_DEPTH    = DEPTH_DEF;
  localparam int MAX_BYTES     = MAX_PAYLOAD_BYTES_DEF;
  localparam int STAGE_WORDS   = (MAX_BYTES + 7) / 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_BEATS  = 48;
  localparam int RANDOM_PHASES = 6;

  typedef struct {
    kind_t       kind;
    logic [7:0]  req;
    logic [7:0]  mk;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  len;
    logic [63:0] word;
    logic        last;
  } beat_t;

  typedef struct {
    status_t     status;
    logic [7:0]  kind;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  len;
    logic [63:0] word;
    logic        last;
    logic [4:0]  occ;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cmf_in_if  in_if ();
  cmf_out_if out_if ();

  checked_message_fifo u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // shadow ring
  logic [7:0]  prod_reg;
  logic [7:0]  cons_reg;
  logic [4:0]  cap_reg;
  logic [31:0] shadow_hdr [RING_DEPTH];
  logic [63:0] shadow_data [RING_DEPTH*STAGE_WORDS];
  logic [63:0] shadow_stage [STAGE_WORDS];
  int          stage_cnt;
  bit          stage_ovf;
  int          rd_idx;
  int          wr_idx;
  int          held;

  reply_t      pending_replies [$];

  int          mismatches;
  int          beats_sent;
  int          replies_seen;
  int          status_seen [6];
  int          burst_left;
  int          hold_req;
  bit          tx_gaps;
  bit          rx_free;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("checked_message_fifo: mismatch");
    $finish;
  end

  function automatic int ring_cap();
    if (cap_reg == 5'd0) return 1;
    if (int'(cap_reg) > RING_DEPTH) return RING_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int next_slot(input int idx);
    return (idx + 1 >= ring_cap()) ? 0 : idx + 1;
  endfunction

  function automatic int words_for(input logic [7:0] len);
    int n;
    n = (int'(len) + 7) / 8;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic reply_t make_reply(input status_t st, input logic [31:0] hdr,
                                        input logic [63:0] word, input logic last);
    reply_t r;
    r.status = st;
    r.kind   = hdr[7:0];
    r.src    = hdr[15:8];
    r.dst    = hdr[23:16];
    r.len    = hdr[31:24];
    r.word   = word;
    r.last   = last;
    r.occ    = 5'(held);
    return r;
  endfunction

  // advance the shadow ring by one accepted beat and queue its replies
  function automatic void ring_apply_beat(input beat_t b);
    status_t     st;
    int          need;
    int          slot;
    int          bytes;
    int          n;
    logic [63:0] v;
    logic [31:0] hdr;
    if (b.kind == KIND_PUSH) begin
      if (stage_cnt < STAGE_WORDS) begin
        shadow_stage[stage_cnt] = b.word;
        stage_cnt++;
      end else begin
        stage_ovf = 1'b1;
      end
      if (!b.last) return;
      need = words_for(b.len);
      if (b.req != prod_reg) begin
        st = ST_BAD_REQ;
      end else if (b.mk == 8'd0 || b.src != prod_reg || b.dst != cons_reg ||
                   (stage_ovf ? need <= STAGE_WORDS : stage_cnt != need)) begin
        st = ST_BAD_HDR;
      end else if (int'(b.len) > MAX_BYTES || stage_ovf) begin
        st = ST_TOO_LONG;
      end else if (held >= ring_cap()) begin
        st = ST_FULL;
      end else begin
        st = ST_OK;
        slot = wr_idx;
        shadow_hdr[slot] = {b.len, b.dst, b.src, b.mk};
        for (int w = 0; w < STAGE_WORDS; w++) begin
          v = '0;
          if (w * 8 < int'(b.len)) begin
            bytes = int'(b.len) - w * 8;
            v = shadow_stage[w];
            if (bytes < 8) v &= (64'd1 << (bytes * 8)) - 64'd1;
          end
          shadow_data[slot*STAGE_WORDS + w] = v;
        end
        wr_idx = next_slot(wr_idx);
        held++;
      end
      stage_cnt = 0;
      stage_ovf = 1'b0;
      pending_replies.push_back(make_reply(st, '0, '0, 1'b1));
    end else if (b.req != cons_reg) begin
      pending_replies.push_back(make_reply(ST_BAD_REQ, '0, '0, 1'b1));
    end else if (held == 0) begin
      pending_replies.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
    end else begin
      slot = rd_idx;
      hdr = shadow_hdr[slot];
      n = words_for(hdr[31:24]);
      if (n > STAGE_WORDS) n = STAGE_WORDS;
      rd_idx = next_slot(rd_idx);
      held--;
      for (int w = 0; w < n; w++) begin
        pending_replies.push_back(make_reply(ST_OK, hdr, shadow_data[slot*STAGE_WORDS + w],
                                             w == n - 1));
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : reply_monitor
    reply_t exp;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      replies_seen++;
      if (int'(out_if.status) < 6) status_seen[int'(out_if.status)]++;
      if (pending_replies.size() == 0) begin
        $error("reply beat with no prediction waiting: status %0d", out_if.status);
        mismatches++;
      end else begin
        exp = pending_replies.pop_front();
        check_field("status", 64'(exp.status), 64'(out_if.status));
        check_field("out_kind", 64'(exp.kind), 64'(out_if.out_kind));
        check_field("out_src", 64'(exp.src), 64'(out_if.out_src));
        check_field("out_dst", 64'(exp.dst), 64'(out_if.out_dst));
        check_field("out_len", 64'(exp.len), 64'(out_if.out_len));
        check_field("out_word", exp.word, out_if.out_word);
        check_field("out_last", 64'(exp.last), 64'(out_if.out_last));
        check_field("occupancy", 64'(exp.occ), 64'(out_if.occupancy));
      end
    end
  end

  // receiver: long hold-off on request, ready if rx_free, else random runs, stalls
  initial begin : reply_sink
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_req--;
      end else if (rx_free) begin
        out_if.ready <= 1'b1;
      end else if (run_left > 0) begin
        out_if.ready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        run_left = $urandom_range(0, 9);
        stall_left = $urandom_range(1, 5);
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input beat_t b);
    in_if.valid          <= 1'b1;
    in_if.kind           <= b.kind;
    in_if.requester_host <= b.req;
    in_if.msg_kind       <= b.mk;
    in_if.msg_src        <= b.src;
    in_if.msg_dst        <= b.dst;
    in_if.payload_len    <= b.len;
    in_if.payload_word   <= b.word;
    in_if.beat_last      <= b.last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ring_apply_beat(b);
    beats_sent++;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic beat_t rand_beat(input kind_t k);
    beat_t b;
    b.kind = k;
    b.req  = 8'($urandom);
    b.mk   = 8'($urandom);
    b.src  = 8'($urandom);
    b.dst  = 8'($urandom);
    b.len  = 8'($urandom);
    b.word = {$urandom, $urandom};
    b.last = 1'($urandom);
    return b;
  endfunction

  task automatic send_pop(input logic [7:0] req);
    beat_t b;
    b = rand_beat(KIND_POP);
    b.req = req;
    send_beat(b);
  endtask

  // header fields ride on the final beat only, earlier beats carry junk
  task automatic send_push(input logic [7:0] req, input logic [7:0] mk, input logic [7:0] src,
                           input logic [7:0] dst, input logic [7:0] len, input int nbeats,
                           input bit mix_pops);
    beat_t b;
    for (int i = 0; i < nbeats; i++) begin
      if (mix_pops && i > 0 && $urandom_range(0, 14) == 0) send_pop(cons_reg);
      b = rand_beat(KIND_PUSH);
      b.last = (i == nbeats - 1);
      if (b.last) begin
        b.req = req;
        b.mk  = mk;
        b.src = src;
        b.dst = dst;
        b.len = len;
      end
      send_beat(b);
    end
  endtask

  task automatic send_good_push(input logic [7:0] len);
    send_push(prod_reg, 8'($urandom_range(1, 255)), prod_reg, cons_reg, len, words_for(len),
              1'b0);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PRODUCER: prod_reg = val;
      CFG_CONSUMER: cons_reg = val;
      default:      cap_reg = val[4:0];
    endcase
    @(posedge clk);
  endtask

  // capacity only changes with the ring empty so no pop reads an unwritten slot
  task automatic drain_ring();
    while (held > 0) send_pop(cons_reg);
    wait_idle();
  endtask

  task automatic test_reset_values();
    send_push(8'd0, 8'h01, 8'd0, 8'd1, 8'd16, 2, 1'b0);
    send_pop(8'd1);
    wait_idle();
    write_reg(CFG_PRODUCER, 8'hFF);
    write_reg(CFG_CONSUMER, 8'h00);
    write_reg(CFG_CAPACITY, 8'd16);
  endtask

  task automatic test_lengths();
    int lens [7] = '{0, 1, 7, 8, 9, 127, 128};
    for (int i = 0; i < 7; i++) begin
      send_push(prod_reg, (i == 0) ? 8'hFF : 8'(i), prod_reg, cons_reg, 8'(lens[i]),
                words_for(8'(lens[i])), 1'b0);
    end
    repeat (8) send_pop(cons_reg);
    wait_idle();
  endtask

  task automatic test_push_checks();
    send_push(prod_reg ^ 8'h01, 8'h10, prod_reg, cons_reg, 8'd8, 1, 1'b0);
    send_push(prod_reg, 8'h00, prod_reg, cons_reg, 8'd8, 1, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg ^ 8'h80, cons_reg, 8'd8, 1, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg ^ 8'h01, 8'd8, 1, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd24, 2, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd24, 4, 1'b0);
    // staging overflow: short claim is a bad header, long claim is too long
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd8, 17, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd129, 17, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd255, 32, 1'b0);
    send_push(prod_reg, 8'h10, prod_reg, cons_reg, 8'd200, 3, 1'b0);
    send_good_push(8'd20);
    send_pop(cons_reg);
    wait_idle();
  endtask

  task automatic test_pop_checks();
    send_good_push(8'd5);
    send_pop(cons_reg ^ 8'h80);
    send_pop(cons_reg);
    send_pop(cons_reg);
    send_pop(cons_reg ^ 8'h01);
    wait_idle();
  endtask

  task automatic test_capacity();
    drain_ring();
    write_reg(CFG_CAPACITY, 8'd3);
    repeat (4) send_good_push(8'd8);
    repeat (2) send_pop(cons_reg);
    repeat (2) send_good_push(8'd12);
    repeat (4) send_pop(cons_reg);
    wait_idle();
    // zero clamps to one slot
    write_reg(CFG_CAPACITY, 8'd0);
    repeat (2) send_good_push(8'd3);
    repeat (2) send_pop(cons_reg);
    wait_idle();
    // above depth clamps to depth
    write_reg(CFG_CAPACITY, 8'd31);
    repeat (17) send_good_push(8'd0);
    drain_ring();
    // upper bits of the write data are not part of the register
    write_reg(CFG_CAPACITY, 8'h25);
    repeat (6) send_good_push(8'd1);
    drain_ring();
    write_reg(CFG_CAPACITY, 8'd16);
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_good_push(8'($urandom_range(1, 32)));
      send_pop(cons_reg);
    end
    wait_idle();
  endtask

  task automatic send_broken_push();
    int         nb;
    logic [7:0] len;
    len = 8'($urandom_range(0, 64));
    case ($urandom_range(0, 3))
      0: send_push(8'($urandom), 8'($urandom_range(1, 255)), prod_reg, cons_reg, len,
                   words_for(len), 1'b1);
      1: send_push(prod_reg, 8'($urandom), 8'($urandom), 8'($urandom), len, words_for(len),
                   1'b1);
      2: begin
        nb = words_for(len) + ($urandom_range(0, 1) ? 1 : -1);
        if (nb < 1) nb = 2;
        send_push(prod_reg, 8'($urandom_range(1, 255)), prod_reg, cons_reg, len, nb, 1'b1);
      end
      default: begin
        len = 8'($urandom_range(MAX_BYTES + 1, 255));
        nb = $urandom_range(1, words_for(len));
        send_push(prod_reg, 8'($urandom_range(1, 255)), prod_reg, cons_reg, len, nb, 1'b1);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int         phase_end;
    int         r;
    logic [7:0] len;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_ring();
      write_reg(CFG_PRODUCER, 8'($urandom));
      write_reg(CFG_CONSUMER, 8'($urandom));
      case (ph)
        0:       write_reg(CFG_CAPACITY, 8'd4);
        1:       write_reg(CFG_CAPACITY, 8'd0);
        2:       write_reg(CFG_CAPACITY, 8'd31);
        3:       write_reg(CFG_CAPACITY, 8'd2);
        4:       write_reg(CFG_CAPACITY, 8'($urandom_range(0, 31)));
        default: write_reg(CFG_CAPACITY, 8'd16);
      endcase
      // one phase runs with no idling on either side
      tx_gaps = (ph != 2);
      rx_free = (ph == 2);
      phase_end = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
      while (beats_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, MAX_BYTES))
                                            : 8'($urandom_range(0, 40));
          send_push(prod_reg, 8'($urandom_range(1, 255)), prod_reg, cons_reg, len,
                    words_for(len), 1'b1);
        end else if (r < 80) begin
          send_pop(cons_reg);
        end else if (r < 85) begin
          send_pop(8'($urandom));
        end else begin
          send_broken_push();
        end
      end
    end
    tx_gaps = 1'b1;
    rx_free = 1'b0;
    drain_ring();
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_PRODUCER;
    cfg_wdata            <= '0;
    in_if.valid          <= 1'b0;
    in_if.kind           <= KIND_PUSH;
    in_if.requester_host <= '0;
    in_if.msg_kind       <= '0;
    in_if.msg_src        <= '0;
    in_if.msg_dst        <= '0;
    in_if.payload_len    <= '0;
    in_if.payload_word   <= '0;
    in_if.beat_last      <= 1'b0;
    prod_reg   = 8'd0;
    cons_reg   = 8'd1;
    cap_reg    = 5'd16;
    stage_cnt  = 0;
    stage_ovf  = 1'b0;
    rd_idx     = 0;
    wr_idx     = 0;
    held       = 0;
    mismatches = 0;
    beats_sent = 0;
    replies_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    burst_left = 0;
    hold_req   = 0;
    tx_gaps    = 1'b1;
    rx_free    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_lengths();
    test_push_checks();
    test_pop_checks();
    test_capacity();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("sent %0d input beats, checked %0d reply beats", beats_sent, replies_seen);
    $display("replies by status ok/req/hdr/long/full/empty: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0) begin
      $display("checked_message_fifo: match");
    end else begin
      $display("checked_message_fifo: mismatch");
    end
    $finish;
  end

endmodule
